// ===== hw/rtl/mdpf_pkg.sv =====
// mdpf_pkg: shared constants, types and the crc-16 byte update for the duty framer
// no dependencies; imported by every module of the framer
`timescale 1ns / 1ps

package mdpf_pkg;

    localparam int DUTY_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int DB_W    = 14;
    localparam int MAG_W   = 14;
    localparam int PROD_W  = 29;
    localparam int IDX_W   = 3;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 2'd1;

    localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RST = 8'd128;
    localparam logic [BYTE_W-1:0] OPCODE_DUTY        = 8'd34;

    localparam logic signed [DUTY_W-1:0] DUTY_FULL_POS = 16'sd10000;
    localparam logic signed [DUTY_W-1:0] DUTY_FULL_NEG = -16'sd10000;
    localparam logic [MAG_W-1:0]         DUTY_FULL_MAG = 14'd10000;

    // positive scale 32767, negative scale 32768 (a shift by 15)
    localparam logic [14:0] SCALE_POS = 15'd32767;
    localparam int          NEG_SHIFT = 15;

    // divide by 10000: x * ceil(2^42 / 10000) >> 42, exact for every x up to 10000 * 32768
    localparam logic [PROD_W-1:0] RECIP_MULT  = 29'd439804652;
    localparam int                RECIP_SHIFT = 42;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // byte positions within a command packet
    localparam logic [IDX_W-1:0] BYTE_ADDR   = 3'd0;
    localparam logic [IDX_W-1:0] BYTE_OPCODE = 3'd1;
    localparam logic [IDX_W-1:0] BYTE_DA_HI  = 3'd2;
    localparam logic [IDX_W-1:0] BYTE_DA_LO  = 3'd3;
    localparam logic [IDX_W-1:0] BYTE_DB_HI  = 3'd4;
    localparam logic [IDX_W-1:0] BYTE_DB_LO  = 3'd5;
    localparam logic [IDX_W-1:0] BYTE_CRC_HI = 3'd6;
    localparam logic [IDX_W-1:0] BYTE_CRC_LO = 3'd7;

    // stage advance strobes from the top level to the scalers
    typedef struct packed {
        logic adv1;
        logic adv2;
    } mdpf_ctl_t;

    // serializer status back to the top level
    typedef struct packed {
        logic busy;
        logic finish;
    } mdpf_ser_st_t;

    // msb-first crc-16, no reflection, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/motor_duty_packet_framer_top.sv =====
// motor_duty_packet_framer_top: duty request in, eight-byte crc-16 command packet out
// depends on mdpf_pkg, mdpf_duty_scale, mdpf_byte_ser
`timescale 1ns / 1ps

//  channel | direction | tdata (low bit up)              | tlast           | tuser
//  s_      | in        | duty_a[15:0], duty_b[31:16]     | -               | -
//  m_      | out       | out_byte[7:0]                   | last_byte       | -
//  cfg_    | in        | write enable, index, 14-bit data| -               | -
//
// each request becomes eight output bytes, one per output request; the byte
// serializer sets that pace
// first byte leaves once the request has passed the input, multiply and divide stages
// up to three requests wait in the input, multiply and divide stages while a
// packet drains; a stall on m_ holds the byte and backs the stages up in turn
// aresetn is synchronous, active low; it empties every stage and restores the
// address register to 128 and the deadband to 0

module motor_duty_packet_framer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // duty_a[15:0], duty_b[31:16]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,
    // out_byte[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [mdpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mdpf_pkg::DB_W-1:0]         cfg_wdata
);
    import mdpf_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] dev_addr_reg;
    logic [DB_W-1:0]   dead_band_reg;

    // input stage
    logic signed [DUTY_W-1:0] da_in_reg, db_in_reg;

    // stage valids: input, multiply, divide
    logic v0_reg, v0_next;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;

    logic          in_take;
    logic          ser_load;
    mdpf_ctl_t     ctl;
    mdpf_ser_st_t  ser_st;
    logic [DUTY_W-1:0] duty_a, duty_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= DEVICE_ADDRESS_RST;
            dead_band_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_DEAD_BAND:      dead_band_reg <= cfg_wdata;
                default:            ;   // unknown index, ignored
            endcase
        end
    end

    // ready chain: a stage moves when the next one is empty or moving on
    assign ser_load = v2_reg && (!ser_st.busy || ser_st.finish);
    assign ctl.adv2 = v1_reg && (!v2_reg || ser_load);
    assign ctl.adv1 = v0_reg && (!v1_reg || ctl.adv2);
    assign s_tready = !v0_reg || ctl.adv1;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        v0_next = in_take ? 1'b1 : (ctl.adv1 ? 1'b0 : v0_reg);
        v1_next = ctl.adv1 ? 1'b1 : (ctl.adv2 ? 1'b0 : v1_reg);
        v2_next = ctl.adv2 ? 1'b1 : (ser_load ? 1'b0 : v2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            da_in_reg <= s_tdata[15:0];
            db_in_reg <= s_tdata[31:16];
        end
    end

    mdpf_duty_scale u_scale_a (
        .aclk      (aclk),
        .ctl       (ctl),
        .duty_in   (da_in_reg),
        .dead_band (dead_band_reg),
        .duty_out  (duty_a)
    );

    mdpf_duty_scale u_scale_b (
        .aclk      (aclk),
        .ctl       (ctl),
        .duty_in   (db_in_reg),
        .dead_band (dead_band_reg),
        .duty_out  (duty_b)
    );

    mdpf_byte_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ser_load),
        .address  (dev_addr_reg),
        .duty_a   (duty_a),
        .duty_b   (duty_b),
        .status   (ser_st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a packet never breaks off before its crc low byte
    a_pkt_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("packet gap before last byte");

    // a freshly loaded packet opens with the device address
    a_first_is_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |=> (m_tvalid && m_tdata == $past(dev_addr_reg) && !m_tlast))
        else $error("packet does not start with address");

    // the divide stage keeps its request until the serializer takes it
    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !ser_load) |=> v2_reg)
        else $error("divide stage request lost");

    // the serializer only loads when it is free or finishing
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |-> (!ser_st.busy || (m_tready && m_tlast)))
        else $error("serializer overwritten mid packet");

endmodule

// ===== hw/rtl/mdpf_duty_scale.sv =====
// mdpf_duty_scale: clamp, deadzone and scale of one duty request, two register stages
// depends on mdpf_pkg
`timescale 1ns / 1ps

module mdpf_duty_scale (
    input  logic                              aclk,
    input  mdpf_pkg::mdpf_ctl_t               ctl,
    input  logic signed [mdpf_pkg::DUTY_W-1:0] duty_in,
    input  logic [mdpf_pkg::DB_W-1:0]          dead_band,
    output logic [mdpf_pkg::DUTY_W-1:0]        duty_out
);
    import mdpf_pkg::*;

    logic [MAG_W-1:0]      mag;
    logic                  neg;
    logic [PROD_W-1:0]     scaled;
    logic [PROD_W-1:0]     x_reg;
    logic                  neg_reg;
    logic [2*PROD_W-1:0]   prod;
    logic [DUTY_W-1:0]     quot;
    logic [DUTY_W-1:0]     duty_reg;

    // clamp to full scale, take the magnitude, zero it below the deadband and scale it
    always_comb begin
        neg = duty_in[DUTY_W-1];
        if (duty_in < DUTY_FULL_NEG || duty_in > DUTY_FULL_POS) begin
            mag = DUTY_FULL_MAG;
        end else if (neg) begin
            mag = MAG_W'(-duty_in);
        end else begin
            mag = MAG_W'(duty_in);
        end
        if (mag < dead_band) begin
            scaled = '0;
        end else if (neg) begin
            scaled = {mag, {NEG_SHIFT{1'b0}}};
        end else begin
            scaled = PROD_W'(mag) * PROD_W'(SCALE_POS);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv1) begin
            x_reg   <= scaled;
            neg_reg <= neg;
        end
    end

    // divide by 10000 through the reciprocal, exact up to 10000 * 32768
    assign prod = {{PROD_W{1'b0}}, x_reg} * {{PROD_W{1'b0}}, RECIP_MULT};
    assign quot = prod[RECIP_SHIFT +: DUTY_W];

    always_ff @(posedge aclk) begin
        if (ctl.adv2) begin
            duty_reg <= neg_reg ? DUTY_W'(-quot) : quot;
        end
    end

    assign duty_out = duty_reg;

endmodule

// ===== hw/rtl/mdpf_byte_ser.sv =====
// mdpf_byte_ser: holds one command packet and sends it a byte per request, crc built on the fly
// depends on mdpf_pkg
`timescale 1ns / 1ps

module mdpf_byte_ser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [mdpf_pkg::BYTE_W-1:0]    address,
    input  logic [mdpf_pkg::DUTY_W-1:0]    duty_a,
    input  logic [mdpf_pkg::DUTY_W-1:0]    duty_b,
    output mdpf_pkg::mdpf_ser_st_t         status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mdpf_pkg::BYTE_W-1:0]    m_tdata,
    output logic                           m_tlast
);
    import mdpf_pkg::*;

    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]       crc_reg, crc_next;
    logic [BYTE_W-1:0] addr_reg;
    logic [DUTY_W-1:0] da_reg, db_reg;
    logic [BYTE_W-1:0] cur_byte;
    logic              take;
    logic              is_last;

    always_comb begin
        case (idx_reg)
            BYTE_ADDR:   cur_byte = addr_reg;
            BYTE_OPCODE: cur_byte = OPCODE_DUTY;
            BYTE_DA_HI:  cur_byte = da_reg[15:8];
            BYTE_DA_LO:  cur_byte = da_reg[7:0];
            BYTE_DB_HI:  cur_byte = db_reg[15:8];
            BYTE_DB_LO:  cur_byte = db_reg[7:0];
            BYTE_CRC_HI: cur_byte = crc_reg[15:8];
            BYTE_CRC_LO: cur_byte = crc_reg[7:0];
            default:     cur_byte = '0;
        endcase
    end

    assign is_last = (idx_reg == BYTE_CRC_LO);
    assign take    = busy_reg && m_tready;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (take) begin
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg < BYTE_CRC_HI) begin
                crc_next = crc16_byte(crc_reg, cur_byte);
            end
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = BYTE_ADDR;
            crc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= BYTE_ADDR;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (load) begin
            addr_reg <= address;
            da_reg   <= duty_a;
            db_reg   <= duty_b;
        end
    end

    assign status.busy   = busy_reg;
    assign status.finish = take && is_last;
    assign m_tvalid      = busy_reg;
    assign m_tdata       = cur_byte;
    assign m_tlast       = is_last;

endmodule
